// ===== design/oaht_pkg.sv =====
// ============================================================================
// oaht_pkg - shared types and codes for the open-address hash table
// Status codes, operation codes, register indexes and the sequencer states.
// ============================================================================
package oaht_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] REG_HASH_MODE  = 2'd0;
    localparam logic [1:0] REG_PROBE_MODE = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd2;
    localparam logic [1:0] REG_MULT_FRAC  = 2'd3;

    localparam logic [1:0] PROBE_NONE   = 2'd0;
    localparam logic [1:0] PROBE_LINEAR = 2'd1;
    localparam logic [1:0] PROBE_DOUBLE = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_MUL_LO,
        S_MUL_HI,
        S_READ,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

// ===== design/oaht_ram.sv =====
// ============================================================================
// oaht_ram - generic single-port synchronous RAM
// Reads every cycle and writes when enabled, at one address; read data registered.
// ============================================================================
module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/oaht_mod.sv =====
// ============================================================================
// oaht_mod - restoring modulo unit
// Reduces a key modulo a divisor, one quotient bit per cycle.
// ============================================================================
module oaht_mod #(
    parameter int KEY_BITS = 31,
    parameter int DW       = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [DW-1:0]       i_div,
    output logic                o_done,
    output logic [DW-1:0]       o_rem
);
    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] r_key;
    logic [DW:0]         r_rem;
    logic [DW-1:0]       r_div;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DW+1:0]       w_shift;
    logic [DW+1:0]       w_sub;

    assign w_shift = {r_rem, r_key[KEY_BITS-1]};
    assign w_sub   = w_shift - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(KEY_BITS);
                r_key  <= i_key;
                r_div  <= i_div;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_key <= r_key << 1;
                r_rem <= w_sub[DW+1] ? w_shift[DW:0] : w_sub[DW:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DW-1:0];
endmodule

// ===== design/open_address_hash_table.sv =====
// ============================================================================
// open_address_hash_table - closed hash table with insert and search
// Home slot by modulo or multiplication, probing none, linear or double hash.
// ============================================================================
// Steps: intake in S_IDLE, both modulo reductions at once in S_MOD, the
//   multiply in S_MUL_LO and S_MUL_HI when hashing by multiplication, then
//   S_READ and S_CHECK for each probed slot, and S_OUT for the result.
// Throughput: one item at a time; the input stalls until the last result is
//   taken. The probe walk does one read of the key/valid RAMs per slot.
// Reset: registers return to their reset values; a clearing pass over every
//   slot then zeroes the valid map before the first item.
// ============================================================================
module open_address_hash_table #(
    parameter int MAX_SLOTS = 1024,
    parameter int KEY_BITS  = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [KEY_BITS-1:0] i_key,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [9:0]          o_slot,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SW = $clog2(MAX_SLOTS + 1);   // holds the size itself
    localparam int DW = (SW > 11) ? SW : 11;     // divisor/size width

    // configuration registers
    logic        r_hash_mode;
    logic [1:0]  r_probe_mode;
    logic [10:0] r_table_size;
    logic [31:0] r_mult_frac;

    oaht_pkg::t_state r_state, n_state;

    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [DW-1:0]       r_size;   // effective size
    logic [DW-1:0]       r_addr;
    logic [DW-1:0]       r_step;
    logic [DW-1:0]       r_left;   // probes remaining
    logic [31:0]         r_frac;
    logic [31:0]         r_prod_lo;
    logic [1:0]          r_status;
    logic [AW-1:0]       r_slot;
    logic [AW-1:0]       r_clr;
    logic                r_out_valid;

    // effective size clamp
    logic [DW-1:0] w_eff;
    always_comb begin
        w_eff = DW'(r_table_size);
        if (r_table_size < 11'd2) begin
            w_eff = DW'(2);
        end else if (DW'(r_table_size) > DW'(MAX_SLOTS)) begin
            w_eff = DW'(MAX_SLOTS);
        end
    end

    // two modulo units: home by size, step by size-1
    logic          w_start;
    logic          w_done_a, w_done_b;
    logic [DW-1:0] w_rem_a, w_rem_b;
    assign w_start = (r_state == oaht_pkg::S_IDLE) && i_valid;

    oaht_mod #(.KEY_BITS(KEY_BITS), .DW(DW)) u_mod_home (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_key(i_key), .i_div(w_eff),
        .o_done(w_done_a), .o_rem(w_rem_a)
    );
    oaht_mod #(.KEY_BITS(KEY_BITS), .DW(DW)) u_mod_step (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_key(i_key), .i_div(w_eff - DW'(1)),
        .o_done(w_done_b), .o_rem(w_rem_b)
    );

    // multiplication: frac = low 32 bits of key*A, built as 16-bit halves
    logic [31:0] w_key32;
    logic [31:0] w_mul_lo;
    logic [31:0] w_frac_hi;
    assign w_key32   = 32'(r_key);
    assign w_mul_lo  = w_key32 * {16'd0, r_mult_frac[15:0]};
    assign w_frac_hi = w_key32 * {16'd0, r_mult_frac[31:16]};

    // memories
    logic          w_we;
    logic [AW-1:0] w_ram_addr;
    logic [KEY_BITS-1:0] w_rkey;
    logic [0:0]    w_rused;
    logic [0:0]    w_wused;

    oaht_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_keys (
        .i_clk(i_clk), .i_we(w_we && r_state != oaht_pkg::S_CLEAR),
        .i_addr(w_ram_addr), .i_wdata(r_key), .o_rdata(w_rkey)
    );
    oaht_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_used (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_ram_addr),
        .i_wdata(w_wused), .o_rdata(w_rused)
    );

    logic [DW-1:0] w_next;
    logic [DW:0]   w_sum;
    assign w_sum  = {1'b0, r_addr} + {1'b0, r_step};
    assign w_next = (w_sum >= {1'b0, r_size}) ? DW'(w_sum - {1'b0, r_size}) : w_sum[DW-1:0];

    always_comb begin
        n_state    = r_state;
        w_we       = 1'b0;
        w_wused    = 1'b0;
        w_ram_addr = r_addr[AW-1:0];
        unique case (r_state)
            oaht_pkg::S_CLEAR: begin
                w_we       = 1'b1;
                w_ram_addr = r_clr;
                if (r_clr == AW'(MAX_SLOTS - 1)) n_state = oaht_pkg::S_IDLE;
            end
            oaht_pkg::S_IDLE: if (i_valid) n_state = oaht_pkg::S_MOD;
            oaht_pkg::S_MOD: if (w_done_a) begin
                n_state = r_hash_mode ? oaht_pkg::S_MUL_LO : oaht_pkg::S_READ;
            end
            oaht_pkg::S_MUL_LO: n_state = oaht_pkg::S_MUL_HI;
            oaht_pkg::S_MUL_HI: n_state = oaht_pkg::S_READ;
            oaht_pkg::S_READ:   n_state = oaht_pkg::S_CHECK;
            oaht_pkg::S_CHECK: begin
                if (!w_rused[0]) begin
                    n_state = oaht_pkg::S_OUT;
                    if (r_op == oaht_pkg::OP_INSERT) begin
                        w_we    = 1'b1;
                        w_wused = 1'b1;
                    end
                end else if (w_rkey == r_key || r_left == DW'(1)) begin
                    n_state = oaht_pkg::S_OUT;
                end else begin
                    n_state = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_OUT: if (!i_stall) n_state = oaht_pkg::S_IDLE;
            default: n_state = oaht_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= oaht_pkg::S_CLEAR;
            r_clr        <= '0;
            r_hash_mode  <= 1'b1;
            r_probe_mode <= oaht_pkg::PROBE_DOUBLE;
            r_table_size <= 11'd1024;
            r_mult_frac  <= 32'd2654435769;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == oaht_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    oaht_pkg::REG_HASH_MODE:  r_hash_mode  <= i_cfg_data[0];
                    oaht_pkg::REG_PROBE_MODE: r_probe_mode <= i_cfg_data[1:0];
                    oaht_pkg::REG_TABLE_SIZE: r_table_size <= i_cfg_data[10:0];
                    oaht_pkg::REG_MULT_FRAC:  r_mult_frac  <= i_cfg_data;
                endcase
            end
            r_out_valid <= (n_state == oaht_pkg::S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            oaht_pkg::S_IDLE: begin
                r_op   <= i_op;
                r_key  <= i_key;
                r_size <= w_eff;
            end
            oaht_pkg::S_MOD: begin
                r_addr     <= w_rem_a;
                r_status   <= oaht_pkg::ST_MISS;
                r_slot     <= '0;
                if (r_probe_mode == oaht_pkg::PROBE_LINEAR) begin
                    r_step <= DW'(1);
                    r_left <= r_size;
                end else if (r_probe_mode == oaht_pkg::PROBE_DOUBLE) begin
                    r_step <= w_rem_b + DW'(1);
                    r_left <= r_size;
                end else begin
                    r_step <= '0;
                    r_left <= DW'(1);
                end
            end
            oaht_pkg::S_MUL_LO: begin
                r_prod_lo <= w_mul_lo;
                r_frac    <= w_frac_hi;
            end
            oaht_pkg::S_MUL_HI: begin
                r_frac <= r_prod_lo + {r_frac[15:0], 16'd0};
            end
            oaht_pkg::S_CHECK: begin
                if (!w_rused[0]) begin
                    if (r_op == oaht_pkg::OP_INSERT) begin
                        r_status <= oaht_pkg::ST_OK;
                        r_slot   <= r_addr[AW-1:0];
                    end
                end else if (w_rkey == r_key) begin
                    r_status <= (r_op == oaht_pkg::OP_INSERT) ? oaht_pkg::ST_DUP
                                                              : oaht_pkg::ST_OK;
                    if (r_op == oaht_pkg::OP_SEARCH) r_slot <= r_addr[AW-1:0];
                end
                r_addr <= w_next;
                r_left <= r_left - DW'(1);
            end
            default: ;
        endcase
        // the home from multiplication replaces the modulo home
        if (r_state == oaht_pkg::S_MUL_HI) begin
            r_addr <= DW'(({{DW{1'b0}}, r_prod_lo + {r_frac[15:0], 16'd0}}
                          * {32'd0, r_size}) >> 32);
        end
    end

    assign o_stall     = (r_state != oaht_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = 10'(r_slot);

    // assertions
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == oaht_pkg::S_OUT) else $error("result outside output");
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != oaht_pkg::ST_OK |-> o_slot == 10'd0)
        else $error("slot not zero on miss");
    a_mods_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_a == w_done_b) else $error("modulo units out of step");
endmodule

// ===== dv/tb_open_address_hash_table.sv =====
// ============================================================================
// tb_open_address_hash_table - self-checking bench for the open-address table
// Drives insert and search beats through a series of register settings. Each
// result beat is checked against a behavioral table model or a typed expectation.
// ============================================================================
module tb_open_address_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 1024;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [30:0] i_key;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [9:0]  o_slot;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    open_address_hash_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Table model: register copies plus the stored keys and the valid map.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] slot;
    } t_lookup;

    logic        mdl_hash_mode;
    logic [1:0]  mdl_probe_mode;
    logic [10:0] mdl_table_size;
    logic [31:0] mdl_mult_frac;
    logic [30:0] mdl_key [NSLOTS];
    logic        mdl_used [NSLOTS];

    t_lookup     lookup_q [$];   // expected result beats, oldest first
    logic [30:0] stored_keys [$];  // keys inserted so far, for hits and dups

    int n_errors;
    int n_items;
    int n_results;
    int n_status [3];
    int n_ins;

    // Walk the table the way the block does; updates the model on insert.
    function automatic t_lookup table_access(logic op, logic [30:0] key);
        t_lookup     res;
        int unsigned size;
        int unsigned addr;
        int unsigned step;
        int unsigned probes;
        logic [63:0] prod;
        res.status = oaht_pkg::ST_MISS;
        res.slot   = '0;
        size = mdl_table_size;
        if (size < 2) size = 2;
        if (size > NSLOTS) size = NSLOTS;
        if (mdl_hash_mode == 1'b0) begin
            addr = key % size;
        end else begin
            prod = {33'd0, key} * {32'd0, mdl_mult_frac};
            prod = {32'd0, prod[31:0]} * 64'(size);
            addr = prod[63:32];
        end
        case (mdl_probe_mode)
            oaht_pkg::PROBE_LINEAR: begin
                step = 1; probes = size;
            end
            oaht_pkg::PROBE_DOUBLE: begin
                step = 1 + key % (size - 1); probes = size;
            end
            default: begin
                step = 0; probes = 1;   // mode 3 behaves as no probing
            end
        endcase
        for (int i = 0; i < probes; i++) begin
            if (!mdl_used[addr % NSLOTS]) begin
                if (op == oaht_pkg::OP_INSERT) begin
                    mdl_used[addr % NSLOTS] = 1'b1;
                    mdl_key[addr % NSLOTS]  = key;
                    res.status = oaht_pkg::ST_OK;
                    res.slot   = 10'(addr % NSLOTS);
                end
                break;
            end
            if (mdl_key[addr % NSLOTS] == key) begin
                if (op == oaht_pkg::OP_INSERT) begin
                    res.status = oaht_pkg::ST_DUP;
                end else begin
                    res.status = oaht_pkg::ST_OK;
                    res.slot   = 10'(addr % NSLOTS);
                end
                break;
            end
            addr += step;
            if (addr >= size) addr -= size;
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks every accepted beat, and drives the stall pattern.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (lookup_q.size() == 0) begin
                flag_mismatch("unexpected result beat, status", o_status, 0);
            end else begin
                want = lookup_q.pop_front();
                if (o_status !== want.status) flag_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot) flag_mismatch("slot", o_slot, want.slot);
            end
        end
    end

    int  hold_left;      // long hold-off requested by the stimulus
    bit  rx_idle_en;     // random stall bursts allowed
    bit  tx_idle_en;     // random gaps between item beats allowed

    initial begin
        int burst;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 18) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item and register drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            oaht_pkg::REG_HASH_MODE:  mdl_hash_mode  = data[0];
            oaht_pkg::REG_PROBE_MODE: mdl_probe_mode = data[1:0];
            oaht_pkg::REG_TABLE_SIZE: mdl_table_size = data[10:0];
            default:                  mdl_mult_frac  = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one item beat; on acceptance queue either the typed expectation
    // (when given) or the model's answer. The model always sees the beat.
    task automatic send_item(logic op, logic [30:0] key, bit typed, t_lookup typed_res);
        t_lookup res;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = table_access(op, key);
        if (res.status == oaht_pkg::ST_OK && op == oaht_pkg::OP_INSERT) begin
            stored_keys.push_back(key);
            n_ins++;
        end
        n_status[res.status]++;
        n_items++;
        lookup_q.push_back(typed ? typed_res : res);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Directed rows under the reset settings (multiplicative hash, double
    // hashing, 1024 slots). Key 0 always hashes to slot 0 by multiplication.
    typedef struct {
        logic        op;
        logic [30:0] key;
        bit          typed;
        logic [1:0]  status;
        logic [9:0]  slot;
    } t_dir_row;

    t_dir_row dir_rows [] = '{
        '{oaht_pkg::OP_SEARCH, 31'd0,         1'b1, oaht_pkg::ST_MISS, 10'd0},  // empty
        '{oaht_pkg::OP_INSERT, 31'd0,         1'b1, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'd0,         1'b1, oaht_pkg::ST_DUP,  10'd0},  // duplicate
        '{oaht_pkg::OP_SEARCH, 31'd0,         1'b1, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b0, oaht_pkg::ST_OK,   10'd0},  // largest key
        '{oaht_pkg::OP_SEARCH, 31'h7FFF_FFFF, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_SEARCH, 31'd1,         1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'h5555_5555, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'h2AAA_AAAA, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_SEARCH, 31'h5555_5555, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_SEARCH, 31'h2AAA_AAAA, 1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'd1024,      1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_INSERT, 31'd1,         1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_SEARCH, 31'd1,         1'b0, oaht_pkg::ST_OK,   10'd0},
        '{oaht_pkg::OP_SEARCH, 31'h4000_0000, 1'b0, oaht_pkg::ST_OK,   10'd0}
    };

    // Register settings for the random phases. Sizes 0, 1 and 2047 are out of
    // range on purpose, probe mode 3 is the unused code, multiplier 0 forces
    // every home slot to 0.
    typedef struct {
        logic        hash_mode;
        logic [1:0]  probe_mode;
        logic [10:0] size;
        logic [31:0] frac;
        int          items;
    } t_phase;

    t_phase phases [] = '{
        '{1'b0, oaht_pkg::PROBE_LINEAR, 11'd2,    32'h9E37_79B9, 40},   // fills at once
        '{1'b0, oaht_pkg::PROBE_NONE,   11'd16,   32'h9E37_79B9, 80},
        '{1'b1, oaht_pkg::PROBE_DOUBLE, 11'd13,   32'h0000_0000, 60},
        '{1'b0, oaht_pkg::PROBE_DOUBLE, 11'd1,    32'h0000_0001, 40},
        '{1'b0, oaht_pkg::PROBE_DOUBLE, 11'd0,    32'h8000_0000, 30},
        '{1'b1, 2'd3,                   11'd37,   32'hFFFF_FFFF, 100},
        '{1'b0, oaht_pkg::PROBE_DOUBLE, 11'd64,   32'h1234_5678, 150},
        '{1'b1, oaht_pkg::PROBE_LINEAR, 11'd2047, 32'h7FFF_FFFF, 90},
        '{1'b1, oaht_pkg::PROBE_DOUBLE, 11'd100,  32'hC0FF_EE01, 200},
        '{1'b0, oaht_pkg::PROBE_LINEAR, 11'd250,  32'h0F0F_0F0F, 170},
        '{1'b1, oaht_pkg::PROBE_DOUBLE, 11'd1024, 32'h9E37_79B9, 150}   // no idling here
    };

    function automatic logic [30:0] pick_key(int unsigned size);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && stored_keys.size() > 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (r < 8)
            return 31'($urandom_range(0, 4 * size + 3));
        return 31'($urandom());
    endfunction

    initial begin
        t_lookup none;
        int unsigned sz;
        none = '0;
        n_errors = 0; n_items = 0; n_results = 0; n_ins = 0;
        n_status = '{0, 0, 0};
        hold_left = 0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        mdl_hash_mode  = 1'b1;
        mdl_probe_mode = oaht_pkg::PROBE_DOUBLE;
        mdl_table_size = 11'd1024;
        mdl_mult_frac  = 32'd2654435769;
        for (int s = 0; s < NSLOTS; s++) begin
            mdl_used[s] = 1'b0;
            mdl_key[s]  = '0;
        end
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = oaht_pkg::OP_INSERT;
        i_key       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = oaht_pkg::REG_HASH_MODE;
        i_cfg_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats; the clearing pass shows up as input stall
        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].typed,
                      t_lookup'{dir_rows[r].status, dir_rows[r].slot});
        drain();

        foreach (phases[p]) begin
            write_reg(oaht_pkg::REG_HASH_MODE,  32'(phases[p].hash_mode));
            write_reg(oaht_pkg::REG_PROBE_MODE, 32'(phases[p].probe_mode));
            write_reg(oaht_pkg::REG_TABLE_SIZE, 32'(phases[p].size));
            write_reg(oaht_pkg::REG_MULT_FRAC,  phases[p].frac);
            if (p == phases.size() - 1) begin
                rx_idle_en = 1'b0;
                tx_idle_en = 1'b0;
            end else begin
                rx_idle_en = ($urandom_range(0, 3) != 0);
                tx_idle_en = ($urandom_range(0, 3) != 0);
            end
            // long receiver hold-off: the block fills and stalls its input
            if (p == 6) hold_left = 400;
            sz = phases[p].size;
            if (sz < 2) sz = 2;
            if (sz > NSLOTS) sz = NSLOTS;
            for (int k = 0; k < phases[p].items; k++)
                send_item(($urandom_range(0, 9) < 6) ? oaht_pkg::OP_INSERT
                                                     : oaht_pkg::OP_SEARCH,
                          pick_key(sz), 1'b0, none);
            drain();
        end

        $display("Ran %0d beats over %0d settings incl. out-of-range size and probe codes.",
                 n_items, phases.size() + 1);
        $display("Expected status: ok %0d (inserts %0d), duplicate %0d, full/miss %0d.",
                 n_status[0], n_ins, n_status[1], n_status[2]);
        if (n_errors == 0 && n_results == n_items) begin
            $display("tb_open_address_hash_table passed");
        end else begin
            $display("tb_open_address_hash_table failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", lookup_q.size());
        $display("tb_open_address_hash_table failed");
        $finish;
    end

endmodule
